[design/lggc_pkg.sv]
// Shared types, constants and elaboration-time helpers for the lift/gain/gamma curve.
package lggc_pkg;

    localparam int FRAC_BITS = 28;             // fraction bits of log2 and exponent
    localparam int Q_BITS    = 31;             // Q1.30 mantissa width
    localparam int N_W       = 6;              // integer part of log2
    localparam int LOG_W     = N_W + FRAC_BITS;
    localparam int KMAG_W    = 9;
    localparam int CFG_W     = 16;
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_LIFT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_GAIN  = 2'd1;
    localparam logic [IDX_W-1:0] REG_INVG  = 2'd2;

    // side info riding along the log2 pipe
    typedef struct packed {
        logic mode;
        logic zero;
    } lggc_lside_t;

    // side info riding along the exp2 pipe
    typedef struct packed {
        logic              mode;
        logic              zero;
        logic              sat;
        logic [KMAG_W-1:0] kmag;
    } lggc_eside_t;

    function automatic logic [63:0] sqrt_floor(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] r;
        logic [63:0] b;
        a = a_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > a)
            b = b >> 2;
        while (b != 0)
        begin
            if (a >= r + b)
            begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-i) in Q1.30, by repeated floor square roots from 2.0
    function automatic logic [Q_BITS-1:0] exp_root(input int i);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int k = 1; k <= i; k++)
            c = sqrt_floor(c << 30);
        return c[Q_BITS-1:0];
    endfunction

    // log2 of a constant, Q.28, same steps as the hardware pipe
    function automatic logic [LOG_W-1:0] log2_const(input logic [63:0] v);
        int          n;
        logic [63:0] m;
        logic [FRAC_BITS-1:0] f;
        n = 0;
        f = '0;
        while (n < 63 && (v >> (n + 1)) != 0)
            n++;
        if (n > 30)
            m = v >> (n - 30);
        else
            m = v << (30 - n);
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                f[FRAC_BITS-1-i] = 1'b1;
            end
        end
        return {N_W'(n), f};
    endfunction

endpackage

[design/lift_gain_gamma_curve.sv]
// Lift/gain/gamma curve: M*(x*(gain-lift)+lift)^(1/gamma), M = 2^CODE_BITS-1.
//
// Input channel in_valid/in_ready carries one word: mode and code. Mode 0
// evaluates the curve at the code; mode 1 treats the code as a grid node and
// evaluates at min(node << GRID_SHIFT, M), returning the value shifted left 4.
// Output channel out_valid/out_ready returns curve_value, one word per input.
// Registers lift_level, gain_level, inverse_gamma are written via wr_en/wr_index/
// wr_data; the user must do so only while no word is in flight (block does not check).
//
// From input accept to output valid a word passes: input register, base
// multiply, 30 stages of log2 (search, normalize, 28 squarings), log
// difference, exponent multiply, split, 28 stages of exp2, final scale and shift.
// Throughput is one word per cycle when not stalled. The whole pipe advances
// together; when the receiver stalls with a word waiting, every stage holds
// and in_ready drops, so nothing is lost or repeated. Reset clears all valid
// bits and loads the register defaults (lift 0, gain 1.0, inverse gamma 1.0).
module lift_gain_gamma_curve
    import lggc_pkg::*;
#(
    parameter int CODE_BITS  = 12,
    parameter int GRID_SHIFT = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [CODE_BITS-1:0] code,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          curve_value,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    localparam int NUM_W = CODE_BITS + 19;
    localparam int VW    = NUM_W - 1;
    localparam int TW    = LOG_W + 2;
    localparam int PW    = CODE_BITS + Q_BITS;
    localparam int WIDE  = CODE_BITS + GRID_SHIFT;
    localparam logic [CODE_BITS-1:0] MAXC = {CODE_BITS{1'b1}};
    localparam logic [LOG_W-1:0] LOG_M = log2_const(64'(MAXC) << 15);

    logic [CFG_W-1:0] lift_level_reg;
    logic [CFG_W-1:0] gain_level_reg;
    logic [CFG_W-1:0] inverse_gamma_reg;
    logic signed [CODE_BITS+16:0] lm_reg;

    logic en;

    // stage 0: input
    logic                 s0_valid_reg;
    logic                 s0_mode_reg;
    logic [CODE_BITS-1:0] s0_code_reg;
    logic [WIDE-1:0]      node_wide;
    logic [CODE_BITS-1:0] code_next;

    // stage 1: base numerator
    logic                    s1_valid_reg;
    logic                    s1_mode_reg;
    logic signed [NUM_W-1:0] s1_num_reg;
    logic signed [NUM_W-1:0] num_next;
    logic signed [18:0]      diff;

    // log pipe
    lggc_lside_t      lside_in;
    logic             lg_valid;
    lggc_lside_t      lg_side;
    logic [LOG_W-1:0] lg_log;

    // stage: log difference
    logic                   d_valid_reg;
    lggc_lside_t            d_side_reg;
    logic signed [LOG_W:0]  d_lg_reg;

    // stage: exponent product
    logic                   t_valid_reg;
    lggc_lside_t            t_side_reg;
    logic                   t_neg_reg;
    logic [TW-1:0]          t_reg;
    logic [LOG_W-1:0]       mag;
    logic [LOG_W+15:0]      t_prod;

    // stage: integer/fraction split
    logic                   k_valid_reg;
    lggc_eside_t            k_side_reg;
    logic [FRAC_BITS-1:0]   k_f_reg;

    // exp pipe
    logic                   ex_valid;
    lggc_eside_t            ex_side;
    logic [Q_BITS-1:0]      ex_r;

    // stage: scale
    logic                   p_valid_reg;
    lggc_eside_t            p_side_reg;
    logic [PW-1:0]          p_prod_reg;

    // output
    logic                   out_valid_reg;
    logic [15:0]            curve_value_reg;
    logic [15:0]            curve_value_next;
    logic [PW-1:0]          shifted;
    logic [6:0]             shamt;
    logic [CODE_BITS-1:0]   y;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lift_level_reg    <= 16'd0;
            gain_level_reg    <= 16'd16384;
            inverse_gamma_reg <= 16'd16384;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_LIFT: lift_level_reg    <= wr_data;
                REG_GAIN: gain_level_reg    <= wr_data;
                REG_INVG: inverse_gamma_reg <= wr_data;
                default:  ;
            endcase
        end
    end

    // lift * M only moves with the registers
    always_ff @(posedge clk)
    begin
        lm_reg <= $signed(lift_level_reg) * $signed({1'b0, MAXC});
    end

    // ---- stage 0
    assign node_wide = {{GRID_SHIFT{1'b0}}, code} << GRID_SHIFT;
    always_comb
    begin
        if (!mode)
            code_next = code;
        else if (node_wide > WIDE'(MAXC))
            code_next = MAXC;
        else
            code_next = node_wide[CODE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= in_valid && in_ready;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_mode_reg <= mode;
            s0_code_reg <= code_next;
        end
    end

    // ---- stage 1
    // 2*gain - lift reaches 163838, so one more bit than 2*gain alone
    assign diff     = $signed({2'b0, gain_level_reg, 1'b0})
                    - 19'($signed(lift_level_reg));
    assign num_next = NUM_W'($signed({1'b0, s0_code_reg}) * diff) + NUM_W'(lm_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mode_reg <= s0_mode_reg;
            s1_num_reg  <= num_next;
        end
    end

    // ---- log2
    assign lside_in.mode = s1_mode_reg;
    assign lside_in.zero = s1_num_reg[NUM_W-1] || (s1_num_reg == '0);

    lggc_log2_pipe #(
        .VW (VW)
    ) u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .in_side   (lside_in),
        .in_v      (s1_num_reg[VW-1:0]),
        .out_valid (lg_valid),
        .out_side  (lg_side),
        .out_log   (lg_log)
    );

    // ---- log difference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= lg_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_side_reg <= lg_side;
            d_lg_reg   <= $signed({1'b0, lg_log}) - $signed({1'b0, LOG_M});
        end
    end

    // ---- exponent = log * inverse_gamma, magnitude truncated
    assign mag    = d_lg_reg[LOG_W] ? LOG_W'(-d_lg_reg) : d_lg_reg[LOG_W-1:0];
    assign t_prod = mag * inverse_gamma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_valid_reg <= 1'b0;
        else if (en)
            t_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_side_reg <= d_side_reg;
            t_neg_reg  <= d_lg_reg[LOG_W];
            t_reg      <= t_prod[LOG_W+15:14];
        end
    end

    // ---- split -E into -K + f
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_valid_reg <= 1'b0;
        else if (en)
            k_valid_reg <= t_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_side_reg.mode <= t_side_reg.mode;
            k_side_reg.zero <= t_side_reg.zero;
            // non-negative exponent: base at or above one, or a zero exponent
            k_side_reg.sat  <= !t_neg_reg || (t_reg == '0);
            k_side_reg.kmag <= KMAG_W'(t_reg[TW-1:FRAC_BITS])
                             + KMAG_W'(t_reg[FRAC_BITS-1:0] != '0);
            k_f_reg         <= FRAC_BITS'(0) - t_reg[FRAC_BITS-1:0];
        end
    end

    // ---- exp2
    lggc_exp2_pipe u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (k_valid_reg),
        .in_side   (k_side_reg),
        .in_f      (k_f_reg),
        .out_valid (ex_valid),
        .out_side  (ex_side),
        .out_r     (ex_r)
    );

    // ---- scale by M
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= ex_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_side_reg <= ex_side;
            p_prod_reg <= MAXC * ex_r;
        end
    end

    // ---- final shift and output word
    assign shamt   = 7'd30 + p_side_reg.kmag[6:0];
    assign shifted = p_prod_reg >> shamt;

    always_comb
    begin
        if (p_side_reg.zero)
            y = '0;
        else if (p_side_reg.sat)
            y = MAXC;
        else if (p_side_reg.kmag >= KMAG_W'(34))
            y = '0;
        else
            y = shifted[CODE_BITS-1:0];
        if (p_side_reg.mode)
            curve_value_next = 16'({y, 4'b0});
        else
            curve_value_next = 16'(y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            curve_value_reg <= curve_value_next;
    end

    assign out_valid   = out_valid_reg;
    assign curve_value = curve_value_reg;

endmodule

[design/lggc_log2_pipe.sv]
// Pipelined log2: leading-one search, normalize, then one squaring step per stage.
module lggc_log2_pipe
    import lggc_pkg::*;
#(
    parameter int VW = 30
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  lggc_lside_t       in_side,
    input  logic [VW-1:0]     in_v,
    output logic              out_valid,
    output lggc_lside_t       out_side,
    output logic [LOG_W-1:0]  out_log
);

    logic                 a_valid_reg;
    lggc_lside_t          a_side_reg;
    logic [VW-1:0]        a_v_reg;
    logic [N_W-1:0]       a_n_reg;
    logic [N_W-1:0]       n_next;
    logic [VW+29:0]       norm_wide;

    logic                 st_valid_reg [0:FRAC_BITS];
    lggc_lside_t          st_side_reg  [0:FRAC_BITS];
    logic [N_W-1:0]       st_n_reg     [0:FRAC_BITS];
    logic [Q_BITS-1:0]    st_m_reg     [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] st_frac_reg  [0:FRAC_BITS];

    // position of the leading one
    always_comb
    begin
        n_next = '0;
        for (int i = 0; i < VW; i++)
            if (in_v[i])
                n_next = N_W'(i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= in_side;
            a_v_reg    <= in_v;
            a_n_reg    <= n_next;
        end
    end

    assign norm_wide = {a_v_reg, 30'b0} >> a_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg[0] <= 1'b0;
        else if (en)
            st_valid_reg[0] <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_side_reg[0] <= a_side_reg;
            st_n_reg[0]    <= a_n_reg;
            st_m_reg[0]    <= norm_wide[Q_BITS-1:0];
            st_frac_reg[0] <= '0;
        end
    end

    for (genvar i = 1; i <= FRAC_BITS; i++)
    begin : g_sq
        logic [2*Q_BITS-1:0]  sq;
        logic [Q_BITS:0]      sh;
        logic [Q_BITS-1:0]    m_next;
        logic [FRAC_BITS-1:0] frac_next;

        assign sq = st_m_reg[i-1] * st_m_reg[i-1];
        assign sh = sq[2*Q_BITS-1:30];

        always_comb
        begin
            frac_next = st_frac_reg[i-1];
            if (sh[Q_BITS])
            begin
                m_next = sh[Q_BITS:1];
                frac_next[FRAC_BITS-i] = 1'b1;
            end
            else
            begin
                m_next = sh[Q_BITS-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_valid_reg[i] <= 1'b0;
            else if (en)
                st_valid_reg[i] <= st_valid_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_side_reg[i] <= st_side_reg[i-1];
                st_n_reg[i]    <= st_n_reg[i-1];
                st_m_reg[i]    <= m_next;
                st_frac_reg[i] <= frac_next;
            end
        end
    end

    assign out_valid = st_valid_reg[FRAC_BITS];
    assign out_side  = st_side_reg[FRAC_BITS];
    assign out_log   = {st_n_reg[FRAC_BITS], st_frac_reg[FRAC_BITS]};

endmodule

[design/lggc_exp2_pipe.sv]
// Pipelined exp2 of a fraction: one root-table multiply per stage, Q1.30.
module lggc_exp2_pipe
    import lggc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  lggc_eside_t          in_side,
    input  logic [FRAC_BITS-1:0] in_f,
    output logic                 out_valid,
    output lggc_eside_t          out_side,
    output logic [Q_BITS-1:0]    out_r
);

    logic                 st_valid [0:FRAC_BITS];
    lggc_eside_t          st_side  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] st_f     [0:FRAC_BITS];
    logic [Q_BITS-1:0]    st_r     [0:FRAC_BITS];

    assign st_valid[0] = in_valid;
    assign st_side[0]  = in_side;
    assign st_f[0]     = in_f;
    assign st_r[0]     = Q_BITS'(64'd1 << 30);

    for (genvar i = 1; i <= FRAC_BITS; i++)
    begin : g_mul
        localparam logic [Q_BITS-1:0] ROOT = exp_root(i);
        logic [2*Q_BITS-1:0] prod;
        logic [Q_BITS-1:0]   r_next;
        logic                valid_reg;
        lggc_eside_t         side_reg;
        logic [FRAC_BITS-1:0] f_reg;
        logic [Q_BITS-1:0]   r_reg;

        assign prod   = st_r[i-1] * ROOT;
        assign r_next = st_f[i-1][FRAC_BITS-i] ? prod[Q_BITS+29:30] : st_r[i-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else if (en)
                valid_reg <= st_valid[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg <= st_side[i-1];
                f_reg    <= st_f[i-1];
                r_reg    <= r_next;
            end
        end

        assign st_valid[i] = valid_reg;
        assign st_side[i]  = side_reg;
        assign st_f[i]     = f_reg;
        assign st_r[i]     = r_reg;
    end

    assign out_valid = st_valid[FRAC_BITS];
    assign out_side  = st_side[FRAC_BITS];
    assign out_r     = st_r[FRAC_BITS];

endmodule

[sim/lggc_curve_checker.sv]
// Checker for the lift/gain/gamma curve: predicts each word and compares results in order.
`timescale 1ns / 1ps
module lggc_curve_checker
    import lggc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             mode,
    input  logic [11:0]      code,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [15:0]      curve_value,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0] wr_data,
    output int               fail_count,
    output int               pending,
    output int               results_seen
);

    localparam longint unsigned MAXC = 64'd4095;

    logic [15:0] lift_q, gain_q, invg_q;
    logic [15:0] expected_values[$];
    longint unsigned root_tab[1:28];

    function automatic longint unsigned root_floor(input longint unsigned a_in);
        longint unsigned a, r, b;
        a = a_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > a)
            b = b >> 2;
        while (b != 0)
        begin
            if (a >= r + b)
            begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Q.28 log2 by repeated squaring of the Q1.30 mantissa
    function automatic longint unsigned log2_fix(input longint unsigned v);
        int              n;
        longint unsigned m, fr;
        n = 0;
        fr = 0;
        while (n < 63 && (v >> (n + 1)) != 0)
            n++;
        if (n > 30)
            m = v >> (n - 30);
        else
            m = v << (30 - n);
        for (int i = 0; i < 28; i++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                fr = fr | (64'd1 << (27 - i));
            end
        end
        return (longint'(n) << 28) | fr;
    endfunction

    function automatic longint unsigned curve_predict(input longint unsigned cval);
        longint          lift, diff, num, lg, e;
        longint unsigned mag, t, q, kmag, f, r, shift;
        lift = longint'($signed(lift_q));
        diff = 2 * longint'(gain_q) - lift;
        num = longint'(cval) * diff + lift * longint'(MAXC);
        if (num <= 0)
            return 0;
        lg = longint'(log2_fix(num)) - longint'(log2_fix(MAXC << 15));
        mag = (lg < 0) ? -lg : lg;
        t = (mag * longint'(invg_q)) >> 14;
        e = (lg < 0) ? -longint'(t) : longint'(t);
        if (e >= 0)
            return MAXC;
        q = -e;
        kmag = (q + (64'd1 << 28) - 1) >> 28;
        f = (kmag << 28) - q;
        r = 64'd1 << 30;
        for (int i = 1; i <= 28; i++)
            if ((f >> (28 - i)) & 1)
                r = (r * root_tab[i]) >> 30;
        shift = 30 + kmag;
        if (shift >= 64)
            return 0;
        t = (MAXC * r) >> shift;
        return (t > MAXC) ? MAXC : t;
    endfunction

    function automatic logic [15:0] word_predict(input logic m, input logic [11:0] c);
        longint unsigned idx;
        if (m)
        begin
            idx = longint'(c) << 7;
            if (idx > MAXC)
                idx = MAXC;
            return 16'(curve_predict(idx) << 4);
        end
        return 16'(curve_predict(c));
    endfunction

    initial
    begin
        longint unsigned c;
        c = 64'd1 << 31;
        for (int i = 1; i <= 28; i++)
        begin
            c = root_floor(c << 30);
            root_tab[i] = c;
        end
        fail_count = 0;
        results_seen = 0;
    end

    assign pending = expected_values.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lift_q <= 16'd0;
            gain_q <= 16'd16384;
            invg_q <= 16'd16384;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_LIFT: lift_q <= wr_data;
                REG_GAIN: gain_q <= wr_data;
                REG_INVG: invg_q <= wr_data;
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_values.push_back(word_predict(mode, code));
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_values.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: unexpected word curve_value=%0d", curve_value);
            end
            else
            begin
                logic [15:0] want;
                want = expected_values.pop_front();
                if (want !== curve_value)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: curve_value expected %0d got %0d", want, curve_value);
                end
            end
        end
    end

endmodule

[sim/tb_lift_gain_gamma_curve.sv]
// Top of the lift/gain/gamma curve testbench: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb_lift_gain_gamma_curve;
    import lggc_pkg::*;

    logic             clk, rst_n;
    logic             in_valid, in_ready, mode;
    logic [11:0]      code;
    logic             out_valid, out_ready;
    logic [15:0]      curve_value;
    logic             wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;
    int               fail_count, pending, results_seen;
    int               send_idle_pct, recv_stall_pct;
    logic             long_hold;
    int               cycle_count;
    int               words_sent;

    lift_gain_gamma_curve dut (.*);

    lggc_curve_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 2000000)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus an optional long hold-off
    always @(posedge clk)
    begin
        if (long_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(input logic m, input logic [11:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        code <= c;
        words_sent++;
        forever
        begin
            @(negedge clk);
            if (in_ready)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic set_curve(input logic [15:0] lift, input logic [15:0] gain,
                             input logic [15:0] invg);
        drain_pipe();
        write_reg(REG_LIFT, lift);
        write_reg(REG_GAIN, gain);
        write_reg(REG_INVG, invg);
    endtask

    task automatic random_words(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(1))
                send_word(1'b0, 12'($urandom));
            else if ($urandom_range(9) < 8)
                send_word(1'b1, 12'($urandom_range(32)));
            else
                send_word(1'b1, 12'($urandom));
        end
    endtask

    logic [15:0] lifts[10] = '{16'h0000, 16'h8000, 16'h7FFF, 16'hF000, 16'h1000,
                               16'h0000, 16'hC000, 16'h2000, 16'h0000, 16'h0400};
    logic [15:0] gains[10] = '{16'h4000, 16'h0000, 16'hFFFF, 16'h3000, 16'h4000,
                               16'h2000, 16'h6000, 16'h0000, 16'h5000, 16'h4800};
    logic [15:0] invgs[10] = '{16'd6554, 16'd32768, 16'd16384, 16'd0, 16'd65535,
                               16'd10923, 16'd20000, 16'd6554, 16'd32768, 16'd9000};

    initial
    begin
        logic [11:0] edge_codes[7];
        logic [11:0] nodes[7];
        edge_codes = '{12'd0, 12'd1, 12'd2048, 12'd4094, 12'd4095,
                       12'hAAA, 12'h555};
        nodes = '{12'd0, 12'd1, 12'd16, 12'd31, 12'd32, 12'd33, 12'd4095};
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = 1'b0;
        code = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        long_hold = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        words_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes in both modes at reset curve, then odd settings
        foreach (edge_codes[i])
            send_word(1'b0, edge_codes[i]);
        foreach (nodes[i])
            send_word(1'b1, nodes[i]);
        set_curve(16'h8000, 16'h0000, 16'd16384);   // base goes negative
        send_word(1'b0, 12'd0);
        send_word(1'b0, 12'd4095);
        send_word(1'b1, 12'd32);
        set_curve(16'h1000, 16'h4000, 16'd0);       // power of zero
        send_word(1'b0, 12'd0);
        send_word(1'b0, 12'd100);
        send_word(1'b1, 12'd5);

        for (int s = 0; s < 10; s++)
        begin
            set_curve(lifts[s], gains[s], invgs[s]);
            case (s % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (s == 4)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                fork
                    begin
                        long_hold = 1'b1;
                        repeat (400) @(posedge clk);
                        long_hold = 1'b0;
                    end
                join_none
            end
            random_words(108);
        end

        in_valid <= 1'b0;
        recv_stall_pct = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
        $display("Sent %0d words over 13 curve settings, %0d results checked",
                 words_sent, results_seen);
        $display("Covered both modes, register extremes and four idle/stall mixes");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[lift_gain_gamma_curve.f]
design/lggc_pkg.sv
design/lggc_log2_pipe.sv
design/lggc_exp2_pipe.sv
design/lift_gain_gamma_curve.sv
sim/lggc_curve_checker.sv
sim/tb_lift_gain_gamma_curve.sv
